// File: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: character codes,
// register indexes, stream widths and the controller/datapath link structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    // Field widths
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int INDEX_W    = 11;
    localparam int OUT_COL_W  = 7;
    localparam int OUT_LINE_W = 5;

    // Stream packing
    localparam int S_DATA_W = 24;  // char_code, cell_index, zero pad
    localparam int M_DATA_W = 32;  // cursor_column, cursor_line, cell_data, zero pad
    localparam int M_PAD_W  = M_DATA_W - OUT_COL_W - OUT_LINE_W - CELL_W;

    // Configuration port
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_TEXT_ATTR  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLANK_ATTR = 4'd1;
    localparam logic [ATTR_W-1:0] TEXT_ATTR_RESET  = 8'h0E;
    localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET = 8'h0F;

    // Actions
    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_HT    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

    // Controller -> datapath commands
    typedef struct packed {
        logic load_item;   // capture the input beat
        logic exec_put;    // apply a character: cursor update, cell write
        logic exec_read;   // issue a screen read
        logic clr_step;    // write one zero cell of the reset sweep
        logic blank_step;  // write one blank cell of the bottom row
        logic load_out;    // move the result into the output register
    } tcw_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic is_read;     // latched item is a read
        logic scroll;      // applying the latched put scrolls the screen
        logic clr_last;    // reset sweep is at its last cell
        logic blank_last;  // blank sweep is at its last cell
        logic out_free;    // output register can take a result
    } tcw_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the text console writer: reset sweep, item accept, execute,
// row blanking after a scroll, and hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire tcw_pkg::tcw_stat_t stat,
    output tcw_pkg::tcw_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_BLANK,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.is_read) begin
                    cmd.exec_read = 1'b1;
                    state_next    = ST_DONE;
                end else begin
                    cmd.exec_put = 1'b1;
                    state_next   = stat.scroll ? ST_BLANK : ST_DONE;
                end
            end
            ST_BLANK: begin
                cmd.blank_step = 1'b1;
                if (stat.blank_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen memory with a ring top-row pointer, cursor logic, attribute
// registers, sweep counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire tcw_pkg::tcw_cmd_t                   cmd,
    output tcw_pkg::tcw_stat_t                       stat,
    input  wire logic                                in_action,
    input  wire logic [tcw_pkg::CHAR_W-1:0]          in_char_code,
    input  wire logic [tcw_pkg::INDEX_W-1:0]         in_cell_index,
    input  wire logic                                cfg_write,
    input  wire logic [tcw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [tcw_pkg::ATTR_W-1:0]          cfg_data,
    input  wire logic                                m_tready,
    output logic                                     m_tvalid,
    output logic [tcw_pkg::OUT_COL_W-1:0]            out_cursor_column,
    output logic [tcw_pkg::OUT_LINE_W-1:0]           out_cursor_line,
    output logic [tcw_pkg::CELL_W-1:0]               out_cell_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int CXW   = $clog2(COLUMNS + TAB_WIDTH);
    localparam int RW    = $clog2(ROWS);
    localparam int TW    = $clog2(TAB_WIDTH);

    // Map a logical cell number onto the ring-ordered memory.
    function automatic logic [AW-1:0] map_addr(input logic [AW-1:0] a,
                                               input logic [AW-1:0] top);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, top};
        if (sum >= (AW+1)'(CELLS)) begin
            sum = sum - (AW+1)'(CELLS);
        end
        return sum[AW-1:0];
    endfunction

    // Item
    logic                          act_reg;
    logic [tcw_pkg::CHAR_W-1:0]    code_reg;
    logic [tcw_pkg::INDEX_W-1:0]   idx_reg;

    // Cursor and ring pointer
    logic [CW-1:0] col_reg;
    logic [TW-1:0] tmod_reg;       // column modulo tab width
    logic [RW-1:0] row_reg;
    logic [AW-1:0] top_reg;        // memory address of logical row 0

    // Sweeps
    logic [AW-1:0] sweep_addr_reg;
    logic [CW-1:0] sweep_col_reg;

    // Attributes
    logic [tcw_pkg::ATTR_W-1:0] text_attr_reg;
    logic [tcw_pkg::ATTR_W-1:0] blank_attr_reg;

    // Memory
    logic [tcw_pkg::CELL_W-1:0] mem [CELLS];
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;
    logic                       mem_we;
    logic [AW-1:0]              mem_wa;
    logic [tcw_pkg::CELL_W-1:0] mem_wd;
    logic [AW-1:0]              rd_addr;

    // Output register
    logic                           out_valid_reg;
    logic [tcw_pkg::OUT_COL_W-1:0]  out_col_reg;
    logic [tcw_pkg::OUT_LINE_W-1:0] out_row_reg;
    logic [tcw_pkg::CELL_W-1:0]     out_data_reg;

    // Cursor arithmetic
    logic           printable;
    logic [CXW-1:0] col_x;
    logic [CXW-1:0] col_raw;
    logic [TW-1:0]  tmod_raw;
    logic           row_inc;
    logic [RW:0]    row_sum;
    logic           scroll;
    logic [CW-1:0]  col_new;
    logic [TW-1:0]  tmod_new;
    logic [RW-1:0]  row_new;
    logic [AW-1:0]  cur_pos;
    logic [AW:0]    top_sum;
    logic [AW-1:0]  top_new;
    logic           in_range;

    assign printable = (code_reg >= tcw_pkg::CH_PRINT_LO) &&
                       (code_reg <= tcw_pkg::CH_PRINT_HI);
    assign col_x     = CXW'(col_reg);

    always_comb begin
        col_raw  = col_x;
        tmod_raw = tmod_reg;
        row_inc  = 1'b0;
        unique case (code_reg)
            tcw_pkg::CH_BS: begin
                if (col_reg != '0) begin
                    col_raw  = col_x - CXW'(1);
                    tmod_raw = (tmod_reg == '0) ? TW'(TAB_WIDTH - 1) : tmod_reg - TW'(1);
                end
            end
            tcw_pkg::CH_HT: begin
                col_raw  = col_x + CXW'(TAB_WIDTH) - CXW'(tmod_reg);
                tmod_raw = '0;
            end
            tcw_pkg::CH_CR: begin
                col_raw  = '0;
                tmod_raw = '0;
            end
            tcw_pkg::CH_LF: begin
                col_raw  = '0;
                tmod_raw = '0;
                row_inc  = 1'b1;
            end
            default: begin
                if (printable) begin
                    col_raw  = col_x + CXW'(1);
                    tmod_raw = (tmod_reg == TW'(TAB_WIDTH - 1)) ? '0 : tmod_reg + TW'(1);
                end
            end
        endcase

        // Wrap past the last column
        if (col_raw >= CXW'(COLUMNS)) begin
            col_new  = '0;
            tmod_new = '0;
            row_inc  = 1'b1;
        end else begin
            col_new  = col_raw[CW-1:0];
            tmod_new = tmod_raw;
        end

        row_sum = {1'b0, row_reg} + (RW+1)'(row_inc);
        scroll  = (row_sum >= (RW+1)'(ROWS));
        row_new = scroll ? RW'(ROWS - 1) : row_sum[RW-1:0];
    end

    assign cur_pos = AW'(AW'(row_reg) * AW'(COLUMNS)) + AW'(col_reg);
    assign top_sum = {1'b0, top_reg} + (AW+1)'(COLUMNS);
    assign top_new = (top_sum >= (AW+1)'(CELLS)) ? '0 : top_sum[AW-1:0];
    assign in_range = (32'(idx_reg) < 32'(CELLS));
    assign rd_addr  = map_addr(AW'(idx_reg), top_reg);

    // Write port select
    always_comb begin
        mem_we = 1'b0;
        mem_wa = sweep_addr_reg;
        mem_wd = '0;
        if (cmd.clr_step) begin
            mem_we = 1'b1;
        end else if (cmd.blank_step) begin
            mem_we = 1'b1;
            mem_wd = {blank_attr_reg, tcw_pkg::CH_SPACE};
        end else if (cmd.exec_put && printable) begin
            mem_we = 1'b1;
            mem_wa = map_addr(cur_pos, top_reg);
            mem_wd = {text_attr_reg, code_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.exec_read) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            act_reg  <= in_action;
            code_reg <= in_char_code;
            idx_reg  <= in_cell_index;
        end
    end

    // Cursor, ring pointer, sweeps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            tmod_reg       <= '0;
            row_reg        <= '0;
            top_reg        <= '0;
            sweep_addr_reg <= '0;
            sweep_col_reg  <= '0;
        end else begin
            if (cmd.exec_put) begin
                col_reg  <= col_new;
                tmod_reg <= tmod_new;
                row_reg  <= row_new;
                if (scroll) begin
                    top_reg        <= top_new;
                    sweep_addr_reg <= top_reg;   // old top row becomes the bottom row
                    sweep_col_reg  <= '0;
                end
            end
            if (cmd.clr_step || cmd.blank_step) begin
                sweep_addr_reg <= sweep_addr_reg + AW'(1);
                sweep_col_reg  <= sweep_col_reg + CW'(1);
            end
        end
    end

    // Attribute registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_attr_reg  <= tcw_pkg::TEXT_ATTR_RESET;
            blank_attr_reg <= tcw_pkg::BLANK_ATTR_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                tcw_pkg::REG_TEXT_ATTR:  text_attr_reg  <= cfg_data;
                tcw_pkg::REG_BLANK_ATTR: blank_attr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_col_reg  <= tcw_pkg::OUT_COL_W'(col_reg);
            out_row_reg  <= tcw_pkg::OUT_LINE_W'(row_reg);
            out_data_reg <= ((act_reg == tcw_pkg::ACT_READ) && in_range) ? rd_data_reg : '0;
        end
    end

    assign stat.is_read    = (act_reg == tcw_pkg::ACT_READ);
    assign stat.scroll     = scroll;
    assign stat.clr_last   = (sweep_addr_reg == AW'(CELLS - 1));
    assign stat.blank_last = (sweep_col_reg == CW'(COLUMNS - 1));
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid          = out_valid_reg;
    assign out_cursor_column = out_col_reg;
    assign out_cursor_line   = out_row_reg;
    assign out_cell_data     = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Character console: a ROWS x COLUMNS screen of 16-bit cells (attribute in
// the high byte, character in the low byte) and a cursor, fed one character
// or one cell read per beat.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------
//   s_      | in        | s_tvalid / s_tready | tuser action, tdata char/index
//   m_      | out       | m_tvalid / m_tready | tdata cursor and cell data
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An item goes from accept to result through accept, execute and hand-off to
// the output register. A put that scrolls adds a blanking pass: the ring
// pointer moves by one row and the freed row is blanked one cell per cycle
// through the single write port of the screen memory.
// After reset, a sweep clears the screen memory with s_tready low;
// configuration writes are taken throughout. A stalled result sits in the
// output register while the next item is accepted and executed.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [tcw_pkg::S_DATA_W-1:0]        s_tdata,  // [7:0] char_code, [18:8] cell_index
    input  wire logic                                s_tuser,  // [0] action
    // Result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [tcw_pkg::M_DATA_W-1:0]             m_tdata,  // [6:0] cursor_column,
                                                               // [11:7] cursor_line,
                                                               // [27:12] cell_data
    // Configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tcw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [tcw_pkg::ATTR_W-1:0]          cfg_data
);

    tcw_pkg::tcw_cmd_t  cmd;
    tcw_pkg::tcw_stat_t stat;

    logic [tcw_pkg::OUT_COL_W-1:0]  out_cursor_column;
    logic [tcw_pkg::OUT_LINE_W-1:0] out_cursor_line;
    logic [tcw_pkg::CELL_W-1:0]     out_cell_data;

    // Attribute registers are plain flops: always take the write.
    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .in_action         (s_tuser),
        .in_char_code      (s_tdata[7:0]),
        .in_cell_index     (s_tdata[18:8]),
        .cfg_write         (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_tready          (m_tready),
        .m_tvalid          (m_tvalid),
        .out_cursor_column (out_cursor_column),
        .out_cursor_line   (out_cursor_line),
        .out_cell_data     (out_cell_data)
    );

    // Pack the result beat, lowest field first
    assign m_tdata = {{tcw_pkg::M_PAD_W{1'b0}}, out_cell_data, out_cursor_line,
                      out_cursor_column};

endmodule

`default_nettype wire

// File: rtl/core/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_port_checks
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_port_checks #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [tcw_pkg::M_DATA_W-1:0]  m_tdata
);

    // Hold a stalled result beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

    // One item in flight: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on two consecutive cycles");

    // Clear pass holds off input right after reset release
    assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_tready)
    else $error("input ready during screen clear");

    // Cursor stays on the screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((ROWS > 31) || (m_tdata[11:7] < ROWS)) &&
                     ((COLUMNS > 127) || (m_tdata[6:0] < COLUMNS)))
    else $error("cursor outside the screen");

endmodule

bind text_console_writer tcw_port_checks #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
